// File: rtl/core/assert_macros.svh
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define HKR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("hkr assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define HKR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("hkr assertion failed");

`endif

// File: rtl/core/hkr_pkg.sv
// shared constants, character table and lookup function for the keyboard decoder
`default_nettype none

package hkr_pkg;

	localparam int CODE_W     = 8;
	localparam int CHAR_W     = 7;
	localparam int IN_SLOTS   = 6;
	localparam int TABLE_SIZE = 57;
	localparam int TBL_IDX_W  = $clog2(TABLE_SIZE);

	// left shift is bit 1, right shift is bit 5
	localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;

	// unshifted column, indexed by usage code
	localparam logic [CHAR_W-1:0] CHAR_LOWER [TABLE_SIZE] = '{
		7'h00, 7'h00, 7'h00, 7'h00,
		7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68,
		7'h69, 7'h6a, 7'h6b, 7'h6c, 7'h6d, 7'h6e, 7'h6f, 7'h70,
		7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78,
		7'h79, 7'h7a,
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30,
		7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b,
		7'h5d, 7'h5c, 7'h00, 7'h3b, 7'h27, 7'h00, 7'h2c, 7'h2e,
		7'h2f
	};

	// shifted column, indexed by usage code
	localparam logic [CHAR_W-1:0] CHAR_UPPER [TABLE_SIZE] = '{
		7'h00, 7'h00, 7'h00, 7'h00,
		7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
		7'h49, 7'h4a, 7'h4b, 7'h4c, 7'h4d, 7'h4e, 7'h4f, 7'h50,
		7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
		7'h59, 7'h5a,
		7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
		7'h28, 7'h29,
		7'h0a, 7'h00, 7'h08, 7'h09, 7'h20, 7'h5f, 7'h2b, 7'h7b,
		7'h7d, 7'h7c, 7'h00, 7'h3a, 7'h22, 7'h00, 7'h3c, 7'h3e,
		7'h3f
	};

	// codes past the table decode to zero
	function automatic logic [CHAR_W-1:0] char_lookup(input logic [CODE_W-1:0] code,
			input logic shifted);
		logic [CHAR_W-1:0] ch;
		ch = '0;
		if (code < CODE_W'(TABLE_SIZE)) begin
			ch = shifted ? CHAR_UPPER[code[TBL_IDX_W-1:0]] : CHAR_LOWER[code[TBL_IDX_W-1:0]];
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/hkr_if.sv
// handshake interfaces for the report input and the character output
`default_nettype none

interface hkr_report_if;
	logic       valid;
	logic       ready;
	logic [7:0] modifier_bits;
	logic [7:0] slot_zero;
	logic [7:0] slot_one;
	logic [7:0] slot_two;
	logic [7:0] slot_three;
	logic [7:0] slot_four;
	logic [7:0] slot_five;

	modport source (output valid, modifier_bits, slot_zero, slot_one, slot_two,
		slot_three, slot_four, slot_five, input ready);
	modport sink (input valid, modifier_bits, slot_zero, slot_one, slot_two,
		slot_three, slot_four, slot_five, output ready);
endinterface

interface hkr_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;

	modport source (output valid, ascii_char, input ready);
	modport sink (input valid, ascii_char, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hkr_lane.sv
// one slot lane: flags a code that is in range and not held in the previous report
`default_nettype none

module hkr_lane
	import hkr_pkg::*;
#(
	parameter int KEY_SLOTS  = 6,
	parameter int CODE_LIMIT = 57
) (
	input  wire logic [CODE_W-1:0] code,
	input  wire logic [CODE_W-1:0] prev [KEY_SLOTS],
	output logic                   hit
);

	logic held;
	logic in_range;

	// compare against every stored key in parallel
	always_comb begin
		held = 1'b0;
		for (int j = 0; j < KEY_SLOTS; j++) begin
			if (prev[j] == code) begin
				held = 1'b1;
			end
		end
	end

	// zero means empty; codes at or above the limit are skipped
	assign in_range = (code != '0) && ({1'b0, code} < (CODE_W+1)'(CODE_LIMIT));
	assign hit      = in_range && !held;

endmodule

`default_nettype wire

// File: rtl/core/hkr_merge.sv
// merge stage: picks the first lane with a new key and decodes it
`default_nettype none

module hkr_merge
	import hkr_pkg::*;
#(
	parameter int KEY_SLOTS = 6
) (
	input  wire logic [KEY_SLOTS-1:0] hit,
	input  wire logic [CODE_W-1:0]    code [KEY_SLOTS],
	input  wire logic [CODE_W-1:0]    modifier_bits,
	output logic      [CHAR_W-1:0]    ascii_char
);

	logic [CODE_W-1:0] sel_code;
	logic              shifted;

	// lowest slot wins; no hit leaves code zero, which decodes to zero
	always_comb begin
		sel_code = '0;
		for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				sel_code = code[i];
			end
		end
	end

	assign shifted    = (modifier_bits & SHIFT_MASK) != '0;
	assign ascii_char = char_lookup(sel_code, shifted);

endmodule

`default_nettype wire

// File: rtl/core/hid_keyboard_report_to_ascii_core.sv
// top level of the boot keyboard report to ascii decoder
`default_nettype none

// Takes one boot keyboard report per word on the report channel and gives one
// ascii word per report on the result channel: the character of the first
// slot whose code is nonzero, below CODE_LIMIT and not held in the previous
// report, shifted when either shift modifier is set, or zero. Each character
// enters the output register, or a one-word skid register while the output
// stalls; one lane per slot compares against the stored keys in parallel, so
// a new report can be taken every cycle while the skid is empty. The two
// registers keep the input ready while one character waits to be taken;
// ready drops only when both hold a character. Stored keys reset to zero.
module hid_keyboard_report_to_ascii_core
	import hkr_pkg::*;
#(
	parameter int KEY_SLOTS  = 6,
	parameter int CODE_LIMIT = 57
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	hkr_report_if.sink     report,
	hkr_char_if.source     result
);

	logic [CODE_W-1:0]    field_arr [IN_SLOTS];
	logic [CODE_W-1:0]    fresh     [KEY_SLOTS];
	logic [CODE_W-1:0]    prev_q    [KEY_SLOTS];
	logic [KEY_SLOTS-1:0] hit;
	logic [CHAR_W-1:0]    new_char;
	logic                 accept;

	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_q;
	logic                 skid_valid_q;
	logic [CHAR_W-1:0]    skid_q;

	assign field_arr[0] = report.slot_zero;
	assign field_arr[1] = report.slot_one;
	assign field_arr[2] = report.slot_two;
	assign field_arr[3] = report.slot_three;
	assign field_arr[4] = report.slot_four;
	assign field_arr[5] = report.slot_five;

	// slots beyond the report fields read as empty
	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
		if (i < IN_SLOTS) begin : g_field
			assign fresh[i] = field_arr[i];
		end else begin : g_empty
			assign fresh[i] = '0;
		end

		hkr_lane #(
			.KEY_SLOTS (KEY_SLOTS),
			.CODE_LIMIT(CODE_LIMIT)
		) u_lane (
			.code(fresh[i]),
			.prev(prev_q),
			.hit (hit[i])
		);
	end

	hkr_merge #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_merge (
		.hit          (hit),
		.code         (fresh),
		.modifier_bits(report.modifier_bits),
		.ascii_char   (new_char)
	);

	assign report.ready = !skid_valid_q;
	assign accept       = report.valid && report.ready;

	// stored keys take every accepted report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < KEY_SLOTS; i++) begin
				prev_q[i] <= fresh[i];
			end
		end
	end

	// output register with skid word behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (result.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !result.ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload moves without reset
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (result.ready) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (out_valid_q && !result.ready) begin
				skid_q <= new_char;
			end else begin
				out_q <= new_char;
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.ascii_char = out_q;

endmodule

`default_nettype wire

// File: rtl/core/hkr_checker.sv
// port checker for the keyboard decoder and its bind to the top level
`default_nettype none

`include "assert_macros.svh"

module hkr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] slot_zero,
	input wire logic [7:0] slot_one,
	input wire logic [7:0] slot_two,
	input wire logic [7:0] slot_three,
	input wire logic [7:0] slot_four,
	input wire logic [7:0] slot_five,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] ascii_char
);

	logic all_empty;
	logic in_take;

	assign all_empty = (slot_zero == 8'd0) && (slot_one == 8'd0) && (slot_two == 8'd0)
		&& (slot_three == 8'd0) && (slot_four == 8'd0) && (slot_five == 8'd0);
	assign in_take   = in_valid && in_ready;

	// stalled word stays valid and unchanged
	`HKR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`HKR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(ascii_char))

	// input backs off only while a character is waiting
	`HKR_ASSERT(a_ready_low, clk, arst_n, !in_ready |-> out_valid)

	// an empty report taken into an idle output gives zero next cycle
	`HKR_ASSERT_NEXT(a_empty_zero, clk, arst_n, in_take && !out_valid && all_empty,
		out_valid && (ascii_char == 7'd0))

endmodule

bind hid_keyboard_report_to_ascii_core hkr_checker u_hkr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (report.valid),
	.in_ready  (report.ready),
	.slot_zero (report.slot_zero),
	.slot_one  (report.slot_one),
	.slot_two  (report.slot_two),
	.slot_three(report.slot_three),
	.slot_four (report.slot_four),
	.slot_five (report.slot_five),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.ascii_char(result.ascii_char)
);

`default_nettype wire

// File: dv/report_char_checker.sv
`timescale 1ns / 1ps
// scoreboard that predicts the character of each keyboard report and checks the output words

module report_char_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	hkr_report_if     report,
	hkr_char_if       result,
	output int        mismatches,
	output int        pending
);

	localparam int NUM_SLOTS  = 6;
	localparam int CODE_LIMIT = 57;

	// key codes of the last accepted report
	logic [7:0] held_keys [NUM_SLOTS];
	// characters still owed by the block, oldest first
	logic [6:0] char_q [$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// boot keyboard usage code to ascii, two columns
	function automatic logic [6:0] key_char(input logic [7:0] code, input logic shifted);
		logic [6:0] ch;
		ch = 7'h00;
		if (code >= 8'd4 && code <= 8'd29) begin
			ch = shifted ? 7'(8'h41 + code - 8'd4) : 7'(8'h61 + code - 8'd4);
		end else if (!shifted && code >= 8'd30 && code <= 8'd38) begin
			ch = 7'(8'h31 + code - 8'd30);
		end else begin
			case (code)
				8'd30: ch = "!";
				8'd31: ch = "@";
				8'd32: ch = "#";
				8'd33: ch = "$";
				8'd34: ch = "%";
				8'd35: ch = "^";
				8'd36: ch = "&";
				8'd37: ch = "*";
				8'd38: ch = "(";
				8'd39: ch = shifted ? ")" : "0";
				8'd40: ch = 7'h0a;
				8'd42: ch = 7'h08;
				8'd43: ch = 7'h09;
				8'd44: ch = " ";
				8'd45: ch = shifted ? "_" : "-";
				8'd46: ch = shifted ? "+" : "=";
				8'd47: ch = shifted ? "{" : "[";
				8'd48: ch = shifted ? "}" : "]";
				8'd49: ch = shifted ? "|" : "\\";
				8'd51: ch = shifted ? ":" : ";";
				8'd52: ch = shifted ? "\"" : "'";
				8'd54: ch = shifted ? "<" : ",";
				8'd55: ch = shifted ? ">" : ".";
				8'd56: ch = shifted ? "?" : "/";
				default: ch = 7'h00;
			endcase
		end
		return ch;
	endfunction

	// first slot with a usable code not held last time decides the character
	function automatic logic [6:0] first_new_char(input logic [7:0] mods,
			input logic [7:0] codes [NUM_SLOTS]);
		logic       shifted;
		logic       found;
		logic       held;
		logic [6:0] ch;
		shifted = mods[1] | mods[5];
		found   = 1'b0;
		ch      = 7'h00;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (!found && codes[i] != 8'd0 && codes[i] < 8'(CODE_LIMIT)) begin
				held = 1'b0;
				for (int j = 0; j < NUM_SLOTS; j++)
					if (held_keys[j] == codes[i])
						held = 1'b1;
				if (!held) begin
					found = 1'b1;
					ch    = key_char(codes[i], shifted);
				end
			end
		end
		return ch;
	endfunction

	// predict on each accepted report, compare on each accepted character word
	always @(posedge clk or negedge arst_n) begin : scoreboard
		logic [7:0] codes [NUM_SLOTS];
		logic [6:0] want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++)
				held_keys[k] = 8'd0;
			char_q.delete();
		end else begin
			if (report.valid && report.ready) begin
				codes[0] = report.slot_zero;
				codes[1] = report.slot_one;
				codes[2] = report.slot_two;
				codes[3] = report.slot_three;
				codes[4] = report.slot_four;
				codes[5] = report.slot_five;
				char_q.insert(char_q.size(), first_new_char(report.modifier_bits, codes));
				for (int k = 0; k < NUM_SLOTS; k++)
					held_keys[k] = codes[k];
			end
			if (result.valid && result.ready) begin
				if (char_q.size() == 0) begin
					report_mismatch($sformatf("character word 0x%02h with no report pending",
						result.ascii_char));
				end else begin
					want = char_q.pop_front();
					if (result.ascii_char !== want)
						report_mismatch($sformatf("ascii_char got 0x%02h, expected 0x%02h",
							result.ascii_char, want));
				end
			end
		end
		pending = char_q.size();
	end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the keyboard report decoder, checked by report_char_checker

module testbench;

	localparam int NUM_RANDOM  = 1480;
	localparam int STALL_LIMIT = 1000;
	localparam int LONG_HOLD   = 80;
	localparam logic [7:0] SHIFT_LEFT  = 8'h02;
	localparam logic [7:0] SHIFT_RIGHT = 8'h20;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   sent;
	int   taken;
	int   idle_cycles;
	logic [7:0] last_slots [6];

	hkr_report_if report_ch ();
	hkr_char_if   char_ch ();

	hid_keyboard_report_to_ascii_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.report (report_ch),
		.result (char_ch)
	);

	report_char_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.report     (report_ch),
		.result     (char_ch),
		.mismatches (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// abort when no word moves on either channel for too long
	always @(posedge clk) begin
		if ((report_ch.valid && report_ch.ready) || (char_ch.valid && char_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a word", idle_cycles);
			$display("hid_keyboard_report_to_ascii_core test failed");
			$finish;
		end
	end

	// offer one report after a random gap and wait until it is taken
	task automatic send_report(input logic [7:0] mods, input logic [7:0] s0, s1, s2, s3, s4, s5);
		int gap;
		if ((sent / 200) % 3 == 2)
			gap = 0;
		else
			gap = $urandom_range(0, 10);
		if (gap > 0) begin
			report_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		report_ch.valid         <= 1'b1;
		report_ch.modifier_bits <= mods;
		report_ch.slot_zero     <= s0;
		report_ch.slot_one      <= s1;
		report_ch.slot_two      <= s2;
		report_ch.slot_three    <= s3;
		report_ch.slot_four     <= s4;
		report_ch.slot_five     <= s5;
		@(posedge clk);
		while (!report_ch.ready) @(posedge clk);
		last_slots = '{s0, s1, s2, s3, s4, s5};
		sent++;
	endtask

	// mostly typing-like reports that keep some held keys, plus noise and repeats
	task automatic send_random_report();
		logic [7:0] mods;
		logic [7:0] s [6];
		int mode;
		int pick;
		mode = $urandom_range(0, 19);
		pick = $urandom_range(0, 7);
		case (pick)
			0: mods = 8'h00;
			1: mods = SHIFT_LEFT;
			2: mods = SHIFT_RIGHT;
			3: mods = SHIFT_LEFT | SHIFT_RIGHT;
			default: mods = 8'($urandom_range(0, 255));
		endcase
		for (int i = 0; i < 6; i++) begin
			if (mode < 14) begin
				pick = $urandom_range(0, 9);
				if (pick < 4)
					s[i] = 8'd0;
				else if (pick < 6)
					s[i] = last_slots[$urandom_range(0, 5)];
				else if (pick < 9)
					s[i] = 8'($urandom_range(1, 56));
				else
					s[i] = 8'($urandom_range(0, 255));
			end else if (mode < 18) begin
				s[i] = 8'($urandom_range(0, 255));
			end else begin
				s[i] = last_slots[i];
			end
		end
		send_report(mods, s[0], s[1], s[2], s[3], s[4], s[5]);
	endtask

	// output side: random holds, quiet stretches, and two long holds to fill the block
	initial begin : char_taker
		int gap;
		@(posedge arst_n);
		forever begin
			if (taken == 400 || taken == 1000)
				gap = LONG_HOLD;
			else if ((taken / 170) % 3 == 1)
				gap = 0;
			else
				gap = $urandom_range(0, 10);
			if (gap > 0) begin
				char_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			char_ch.ready <= 1'b1;
			@(posedge clk);
			while (!char_ch.valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		sent        = 0;
		taken       = 0;
		idle_cycles = 0;
		last_slots  = '{default: 8'd0};
		arst_n                  <= 1'b0;
		report_ch.valid         <= 1'b0;
		report_ch.modifier_bits <= 8'd0;
		report_ch.slot_zero     <= 8'd0;
		report_ch.slot_one      <= 8'd0;
		report_ch.slot_two      <= 8'd0;
		report_ch.slot_three    <= 8'd0;
		report_ch.slot_four     <= 8'd0;
		report_ch.slot_five     <= 8'd0;
		char_ch.ready           <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty report, both shift keys, table edges, skipped codes
		send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(8'h00, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(SHIFT_LEFT, 8'd4, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(SHIFT_RIGHT, 8'd56, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(8'hDD, 8'd39, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(8'hFF, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		// codes at and over the limit skipped, unmapped first new key wins over later ones
		send_report(8'h00, 8'd57, 8'd255, 8'd0, 8'd1, 8'd4, 8'd0);
		send_report(8'h00, 8'd41, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(8'h00, 8'd50, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(SHIFT_LEFT | SHIFT_RIGHT, 8'd53, 8'd6, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(8'h00, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0);
		// new key in the last slot, held key ahead of a new one
		send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd40);
		send_report(8'h00, 8'd40, 8'd0, 8'd0, 8'd0, 8'd0, 8'd42);
		send_report(8'h00, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		send_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
		send_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
		send_report(8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd10);
		send_report(8'h00, 8'h80, 8'hAA, 8'h55, 8'h7F, 8'h01, 8'hFE);
		// punctuation in the shifted column, then a letter and a digit
		send_report(SHIFT_LEFT | SHIFT_RIGHT, 8'd44, 8'd43, 8'd45, 8'd46, 8'd47, 8'd48);
		send_report(SHIFT_LEFT, 8'd49, 8'd51, 8'd52, 8'd54, 8'd55, 8'd56);
		send_report(SHIFT_RIGHT, 8'd29, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_report(8'h5D, 8'd29, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0);

		for (int n = 0; n < NUM_RANDOM; n++)
			send_random_report();
		report_ch.valid <= 1'b0;

		// let the scoreboard see the last report before polling its count
		@(posedge clk);
		// drain, then keep clocking to catch stray words
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d reports (22 directed, rest random), took %0d characters,",
			sent, taken);
		$display("output held off for %0d cycles twice to back up the input", LONG_HOLD);
		if (fail_count == 0) begin
			$display("hid_keyboard_report_to_ascii_core test passed");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("hid_keyboard_report_to_ascii_core test failed");
		end
		$finish;
	end

endmodule
